### design/volume_box_average_downsample_unit_macros.svh
// assertion macros shared by the box average downsample design
// no dependencies
`ifndef VOLUME_BOX_AVERAGE_DOWNSAMPLE_UNIT_MACROS_SVH
`define VOLUME_BOX_AVERAGE_DOWNSAMPLE_UNIT_MACROS_SVH

// same-cycle implication
`define VBAD_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("vbad implication check failed");

// next-cycle implication
`define VBAD_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("vbad next-cycle check failed");

`endif

### design/vbad_pkg.sv
// types, register codes and widths of the box average downsample unit
// no dependencies
package vbad_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_FACTOR_DEF = 16;

   localparam int SAMPLE_W  = 16;
   localparam int AVG_W     = 24;
   localparam int FACTOR_W  = 5;
   localparam int SIZE_XY_W = 9;
   localparam int SIZE_Z_W  = 16;
   localparam int SUM_W     = 32;
   localparam int FRAC_W    = 8;
   localparam int DIV_W     = SUM_W + FRAC_W;
   localparam int DVS_W     = 16;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [2:0] REG_FACTOR_X = 3'd0;
   localparam logic [2:0] REG_FACTOR_Y = 3'd1;
   localparam logic [2:0] REG_FACTOR_Z = 3'd2;
   localparam logic [2:0] REG_SIZE_X   = 3'd3;
   localparam logic [2:0] REG_SIZE_Y   = 3'd4;
   localparam logic [2:0] REG_SIZE_Z   = 3'd5;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DX,
      SEQ_DY,
      SEQ_DZ,
      SEQ_PX,
      SEQ_PY,
      SEQ_PZ
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/vbad_if.sv
// request and result channel interfaces of the box average downsample unit
// depends on vbad_pkg
interface vbad_req_if import vbad_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface vbad_rsp_if import vbad_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [AVG_W-1:0] average;
   logic                    volume_end;
   modport source (output valid, output average, output volume_end, input ready);
   modport sink (input valid, input average, input volume_end, output ready);
endinterface

### design/vbad_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on vbad_pkg
module vbad_divider import vbad_pkg::*; #(
   parameter int DW = DIV_W,
   parameter int VW = DVS_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DW-1:0]  dividend,
   input  logic [VW-1:0]  divisor,
   output div_status_type status,
   output logic [DW-1:0]  quotient,
   output logic [VW-1:0]  remainder
);
   localparam int CW = (DW > 1) ? $clog2(DW) : 1;

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW-1:0] num_ff;
   logic [VW-1:0] rem_ff, dvs_ff, rem_nx;
   logic [CW-1:0] count_ff;
   logic [VW:0]   rem_sh;
   logic          ge;

   always_comb begin
      rem_sh = {rem_ff, num_ff[DW-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_nx = ge ? VW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[VW-1:0];
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && count_ff == CW'(DW - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff   <= dividend;
         rem_ff   <= '0;
         dvs_ff   <= divisor;
         count_ff <= '0;
      end else if (busy_ff) begin
         num_ff   <= {num_ff[DW-2:0], ge};
         rem_ff   <= rem_nx;
         count_ff <= count_ff + 1'b1;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;
   assign remainder   = rem_ff;

endmodule

### design/volume_box_average_downsample_unit.sv
// top level of the 3d box average downsample unit
// depends on vbad_pkg, vbad_if, vbad_divider and the assertion macro header
//
// Voxels enter on the req channel in raster order (x fastest, then y, then z);
// block means leave on the rsp channel as signed values with 8 fraction bits,
// volume_end marking the last block of the volume. Registers are written over
// the csr APB port (factor x/y/z, size x/y/z at byte addresses 0..20).
// Running block sums for one output slab live in a single-port-write,
// registered-read memory; each voxel inside a whole block does one
// read-modify-write, with forwarding of the previous write.
// A voxel that closes no block causes no stall. A voxel that closes
// a block starts the shared bit-serial divider: req ready stays low until
// the mean has left the skid register for the output register.
// After reset and after any register write the same divider recomputes the
// block counts and block positions, with req ready low meanwhile.
// A stalled receiver holds one result in the output register and one in a
// skid register; voxels are still taken while only the output register is
// full, and the request side waits while the skid register is occupied.
`include "volume_box_average_downsample_unit_macros.svh"

module volume_box_average_downsample_unit import vbad_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
   input  logic              clock,
   input  logic              reset,
   vbad_req_if.sink          req,
   vbad_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SIZE_XY_W-1:0] MW = (MAX_WIDTH > 511) ? 9'd511 : SIZE_XY_W'(MAX_WIDTH);
   localparam logic [SIZE_XY_W-1:0] MH = (MAX_HEIGHT > 511) ? 9'd511 : SIZE_XY_W'(MAX_HEIGHT);
   localparam logic [FACTOR_W-1:0]  MF = (MAX_FACTOR > 31) ? 5'd31 : FACTOR_W'(MAX_FACTOR);

   // registers
   logic [FACTOR_W-1:0]  factor_x_ff, factor_y_ff, factor_z_ff;
   logic [SIZE_XY_W-1:0] size_x_ff, size_y_ff;
   logic [SIZE_Z_W-1:0]  size_z_ff;
   logic                 cfg_wr;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_x_ff <= 5'd1;
         factor_y_ff <= 5'd1;
         factor_z_ff <= 5'd2;
         size_x_ff   <= 9'd256;
         size_y_ff   <= 9'd256;
         size_z_ff   <= 16'd256;
      end else if (cfg_wr) begin
         case (csr_paddr[4:2])
            REG_FACTOR_X: factor_x_ff <= csr_pwdata[FACTOR_W-1:0];
            REG_FACTOR_Y: factor_y_ff <= csr_pwdata[FACTOR_W-1:0];
            REG_FACTOR_Z: factor_z_ff <= csr_pwdata[FACTOR_W-1:0];
            REG_SIZE_X:   size_x_ff   <= csr_pwdata[SIZE_XY_W-1:0];
            REG_SIZE_Y:   size_y_ff   <= csr_pwdata[SIZE_XY_W-1:0];
            REG_SIZE_Z:   size_z_ff   <= csr_pwdata[SIZE_Z_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_FACTOR_X: csr_prdata = CSR_DW'(factor_x_ff);
         REG_FACTOR_Y: csr_prdata = CSR_DW'(factor_y_ff);
         REG_FACTOR_Z: csr_prdata = CSR_DW'(factor_z_ff);
         REG_SIZE_X:   csr_prdata = CSR_DW'(size_x_ff);
         REG_SIZE_Y:   csr_prdata = CSR_DW'(size_y_ff);
         REG_SIZE_Z:   csr_prdata = CSR_DW'(size_z_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // effective geometry
   logic [SIZE_XY_W-1:0] sx, sy;
   logic [SIZE_Z_W-1:0]  sz;
   logic [FACTOR_W-1:0]  fx, fy, fz, ex, ey, ez;
   logic [9:0]           exy_ff;
   logic [DVS_W-1:0]     cnt_ff;

   always_comb begin
      sx = (size_x_ff == '0) ? 9'd1 : ((size_x_ff > MW) ? MW : size_x_ff);
      sy = (size_y_ff == '0) ? 9'd1 : ((size_y_ff > MH) ? MH : size_y_ff);
      sz = (size_z_ff == '0) ? 16'd1 : size_z_ff;
      fx = (factor_x_ff == '0) ? 5'd1 : ((factor_x_ff > MF) ? MF : factor_x_ff);
      fy = (factor_y_ff == '0) ? 5'd1 : ((factor_y_ff > MF) ? MF : factor_y_ff);
      fz = (factor_z_ff == '0) ? 5'd1 : ((factor_z_ff > MF) ? MF : factor_z_ff);
      ex = (SIZE_XY_W'(fx) < sx) ? fx : sx[FACTOR_W-1:0];
      ey = (SIZE_XY_W'(fy) < sy) ? fy : sy[FACTOR_W-1:0];
      ez = (SIZE_Z_W'(fz) < sz) ? fz : sz[FACTOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      exy_ff <= 10'(ex) * 10'(ey);
      cnt_ff <= DVS_W'(exy_ff) * DVS_W'(ez);
   end

   // shared divider
   logic                  div_start, seq_start, seq_cap, emit_start;
   logic [DIV_W-1:0]      div_num, seq_num, div_q;
   logic [DVS_W-1:0]      div_dvs, seq_dvs, div_r;
   div_status_type        div_st;

   vbad_divider #(.DW(DIV_W), .VW(DVS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_dvs),
      .status    (div_st),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // recompute sequencer
   seq_state_type        seq_ff, seq_in;
   logic                 wait_ff, wait_in;
   logic [SIZE_XY_W-1:0] dx_ff, dy_ff, pos_x_ff, pos_y_ff, bx_ff, by_ff;
   logic [SIZE_Z_W-1:0]  dz_ff, pos_z_ff, bz_ff;
   logic [FACTOR_W-1:0]  ox_ff, oy_ff, oz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= SEQ_DX;
         wait_ff <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         wait_ff <= wait_in;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      wait_in   = wait_ff;
      seq_start = 1'b0;
      seq_cap   = 1'b0;
      seq_num   = '0;
      seq_dvs   = '0;
      case (seq_ff)
         SEQ_DX: begin
            seq_num = DIV_W'(sx);
            seq_dvs = DVS_W'(ex);
         end
         SEQ_DY: begin
            seq_num = DIV_W'(sy);
            seq_dvs = DVS_W'(ey);
         end
         SEQ_DZ: begin
            seq_num = DIV_W'(sz);
            seq_dvs = DVS_W'(ez);
         end
         SEQ_PX: begin
            seq_num = DIV_W'(pos_x_ff);
            seq_dvs = DVS_W'(ex);
         end
         SEQ_PY: begin
            seq_num = DIV_W'(pos_y_ff);
            seq_dvs = DVS_W'(ey);
         end
         SEQ_PZ: begin
            seq_num = DIV_W'(pos_z_ff);
            seq_dvs = DVS_W'(ez);
         end
         default: ;
      endcase
      if (seq_ff != SEQ_IDLE) begin
         if (!wait_ff) begin
            seq_start = 1'b1;
            wait_in   = 1'b1;
         end else if (div_st.done) begin
            seq_cap = 1'b1;
            wait_in = 1'b0;
            case (seq_ff)
               SEQ_DX:  seq_in = SEQ_DY;
               SEQ_DY:  seq_in = SEQ_DZ;
               SEQ_DZ:  seq_in = SEQ_PX;
               SEQ_PX:  seq_in = SEQ_PY;
               SEQ_PY:  seq_in = SEQ_PZ;
               default: seq_in = SEQ_IDLE;
            endcase
         end
      end
      if (cfg_wr) begin
         seq_in  = SEQ_DX;
         wait_in = 1'b0;
      end
   end

   // voxel position and block counters
   logic       accept, in_range, first, last, vend;
   logic       s1_vld_ff, emit_pend_ff, hold_vld_ff;
   logic       s1_first_ff, s1_last_ff, s1_vend_ff;
   logic       wrap_x, wrap_y, wrap_z;
   logic [AW-1:0] idx_full;

   always_comb begin
      in_range = (bx_ff < dx_ff) && (by_ff < dy_ff) && (bz_ff < dz_ff);
      first    = (ox_ff == '0) && (oy_ff == '0) && (oz_ff == '0);
      last     = (ox_ff == ex - 1'b1) && (oy_ff == ey - 1'b1) && (oz_ff == ez - 1'b1);
      vend     = (bx_ff == dx_ff - 1'b1) && (by_ff == dy_ff - 1'b1)
                 && (bz_ff == dz_ff - 1'b1);
      idx_full = AW'(by_ff) * AW'(dx_ff) + AW'(bx_ff);
      wrap_x   = 10'(pos_x_ff) + 10'd1 >= 10'(sx);
      wrap_y   = 10'(pos_y_ff) + 10'd1 >= 10'(sy);
      wrap_z   = 17'(pos_z_ff) + 17'd1 >= 17'(sz);
   end

   assign req.ready = (seq_ff == SEQ_IDLE) && !emit_pend_ff && !hold_vld_ff
                      && !(s1_vld_ff && s1_last_ff);
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (seq_cap) begin
         case (seq_ff)
            SEQ_DX: dx_ff <= div_q[SIZE_XY_W-1:0];
            SEQ_DY: dy_ff <= div_q[SIZE_XY_W-1:0];
            SEQ_DZ: dz_ff <= div_q[SIZE_Z_W-1:0];
            SEQ_PX: begin
               bx_ff <= div_q[SIZE_XY_W-1:0];
               ox_ff <= div_r[FACTOR_W-1:0];
            end
            SEQ_PY: begin
               by_ff <= div_q[SIZE_XY_W-1:0];
               oy_ff <= div_r[FACTOR_W-1:0];
            end
            SEQ_PZ: begin
               bz_ff <= div_q[SIZE_Z_W-1:0];
               oz_ff <= div_r[FACTOR_W-1:0];
            end
            default: ;
         endcase
      end else if (accept) begin
         if (!wrap_x) begin
            pos_x_ff <= pos_x_ff + 1'b1;
            if (ox_ff == ex - 1'b1) begin
               ox_ff <= '0;
               bx_ff <= bx_ff + 1'b1;
            end else begin
               ox_ff <= ox_ff + 1'b1;
            end
         end else begin
            pos_x_ff <= '0;
            ox_ff    <= '0;
            bx_ff    <= '0;
            if (!wrap_y) begin
               pos_y_ff <= pos_y_ff + 1'b1;
               if (oy_ff == ey - 1'b1) begin
                  oy_ff <= '0;
                  by_ff <= by_ff + 1'b1;
               end else begin
                  oy_ff <= oy_ff + 1'b1;
               end
            end else begin
               pos_y_ff <= '0;
               oy_ff    <= '0;
               by_ff    <= '0;
               if (!wrap_z) begin
                  pos_z_ff <= pos_z_ff + 1'b1;
                  if (oz_ff == ez - 1'b1) begin
                     oz_ff <= '0;
                     bz_ff <= bz_ff + 1'b1;
                  end else begin
                     oz_ff <= oz_ff + 1'b1;
                  end
               end else begin
                  pos_z_ff <= '0;
                  oz_ff    <= '0;
                  bz_ff    <= '0;
               end
            end
         end
      end
   end

   // sum memory read-modify-write
   logic signed [SUM_W-1:0]    sum_mem [DEPTH];
   logic signed [SUM_W-1:0]    rd_q_ff, wr_sum_ff, base, sum;
   logic [AW-1:0]              s1_idx_ff, wr_idx_ff;
   logic                       wr_vld_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept && in_range;
         if (s1_vld_ff) begin
            wr_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_q_ff      <= sum_mem[idx_full];
         s1_idx_ff    <= idx_full;
         s1_first_ff  <= first;
         s1_last_ff   <= last;
         s1_vend_ff   <= vend;
         s1_sample_ff <= req.sample;
      end
      if (s1_vld_ff) begin
         sum_mem[s1_idx_ff] <= sum;
         wr_idx_ff          <= s1_idx_ff;
         wr_sum_ff          <= sum;
      end
   end

   always_comb begin
      base = (wr_vld_ff && wr_idx_ff == s1_idx_ff) ? wr_sum_ff : rd_q_ff;
      sum  = s1_first_ff ? SUM_W'(s1_sample_ff) : base + SUM_W'(s1_sample_ff);
   end

   // emit path
   logic [SUM_W-1:0]        mag;
   logic                    sign_ff, pend_vend_ff, hold_vend_ff;
   logic signed [AVG_W-1:0] hold_avg_ff, avg_ff;
   logic                    rsp_valid_ff, vend_ff, load_out;

   assign emit_start = s1_vld_ff && s1_last_ff;
   assign mag        = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign div_start  = seq_start || emit_start;
   assign div_num    = emit_start ? {mag, {FRAC_W{1'b0}}} : seq_num;
   assign div_dvs    = emit_start ? cnt_ff : seq_dvs;
   assign load_out   = hold_vld_ff && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_pend_ff <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_start) begin
            emit_pend_ff <= 1'b1;
         end else if (emit_pend_ff && div_st.done) begin
            emit_pend_ff <= 1'b0;
         end
         if (emit_pend_ff && div_st.done) begin
            hold_vld_ff <= 1'b1;
         end else if (load_out) begin
            hold_vld_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_start) begin
         sign_ff      <= sum[SUM_W-1];
         pend_vend_ff <= s1_vend_ff;
      end
      if (emit_pend_ff && div_st.done) begin
         hold_avg_ff  <= sign_ff ? -div_q[AVG_W-1:0] : div_q[AVG_W-1:0];
         hold_vend_ff <= pend_vend_ff;
      end
      if (load_out) begin
         avg_ff  <= hold_avg_ff;
         vend_ff <= hold_vend_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.average    = avg_ff;
   assign rsp.volume_end = vend_ff;

   `VBAD_ASSERT_IMP(a_div_free, clock, reset, emit_start, !div_st.busy)
   `VBAD_ASSERT_NXT(a_emit_started, clock, reset, emit_start, emit_pend_ff)
   `VBAD_ASSERT_NXT(a_hold_keeps, clock, reset, hold_vld_ff && rsp_valid_ff && !rsp.ready,
                    hold_vld_ff)

endmodule
